// ----- sv/dda_pkg.sv -----
// shared constants, codes and types of the dda line rasterizer
package dda_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // request codes
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV_X,
        S_DIV_Y,
        S_OUT
    } t_state;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- sv/dda_if.sv -----
// request and pixel channel interfaces of the dda line rasterizer
interface dda_req_if #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface dda_pix_if #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         is_last;
    logic                         no_line;

    modport source (
        output valid, pixel_x, pixel_y, is_last, no_line,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, is_last, no_line,
        output ready
    );
endinterface

// ----- sv/dda_div.sv -----
// shared restoring divider, one quotient bit per cycle
module dda_div #(
    parameter int NUM_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int QUO_BITS = dda_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_BITS-1:0]   i_num,
    input  logic [NUM_BITS-1:0]   i_den,
    output dda_pkg::t_div_stat    o_stat,
    output logic [QUO_BITS-1:0]   o_quo
);
    localparam int CNT_W = $clog2(QUO_BITS + 1);

    logic [NUM_BITS:0]   r_rem, n_rem;
    logic [NUM_BITS-1:0] r_den;
    logic [QUO_BITS-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [NUM_BITS:0]   rem_diff;
    logic                rem_ge;
    logic [NUM_BITS:0]   rem_kept;

    // compare and subtract, then shift for the next bit
    always_comb begin
        rem_diff = r_rem - {1'b0, r_den};
        rem_ge   = (r_rem >= {1'b0, r_den});
        rem_kept = rem_ge ? rem_diff : r_rem;
        n_rem    = {rem_kept[NUM_BITS-1:0], 1'b0};
        n_quo    = {r_quo[QUO_BITS-2:0], rem_ge};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(QUO_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

// ----- sv/dda_line_rasterizer.sv -----
// dda line rasterizer top level: sequencer, position state and output word
//
// Request channel i_req carries a word per request. req_type start brings
// two endpoints; req_type advance moves to the next point. Every accepted
// request gives exactly one word on o_pix: the pixel (position truncated
// toward zero), is_last on the final point of the line, and no_line when an
// advance finds no active line (coordinates and is_last then zero).
// A start sets length to the larger axis difference and divides each axis
// difference by it into a fixed-point step on one shared restoring divider,
// one quotient bit per cycle, x first then y (no division when the line
// has zero length). An advance is one add per axis; its word passes from the
// output state into the output register, and the next request can be taken
// once the sequencer has gone back to idle after loading the output word.
// One request is worked on at a time; i_req.ready is high only while the
// sequencer waits for a request, and it stays high while a finished word
// is held in the output register. If o_pix is stalled the sequencer holds
// its result until the output register is free.
// Reset clears the line state (no active line) and empties the output.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dda_req_if.sink   i_req,
    dda_pix_if.source o_pix
);
    localparam int DW     = COORD_BITS + 1;
    localparam int POS_W  = COORD_BITS + 1 + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int LEFT_W = COORD_BITS + 1;
    localparam logic [POS_W-1:0] HALF      = POS_W'(1) << (FRAC_BITS - 1);
    localparam logic [POS_W-1:0] FRAC_MASK = (POS_W'(1) << FRAC_BITS) - POS_W'(1);

    dda_pkg::t_state r_state, n_state;

    logic signed [COORD_BITS-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [COORD_BITS-1:0] n_x1, n_y1, n_x2, n_y2;
    logic [POS_W-1:0]      r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [STEP_W-1:0]     r_step_x, r_step_y, n_step_x, n_step_y;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_active, n_active;
    logic                  r_last, n_last;
    logic                  r_noline, n_noline;
    logic [COORD_BITS-1:0] r_len, n_len;
    logic [COORD_BITS-1:0] r_ay, n_ay;
    logic                  r_neg_x, r_neg_y, n_neg_x, n_neg_y;

    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_pix_x, r_pix_y, n_pix_x, n_pix_y;
    logic                  r_is_last, r_no_line, n_is_last, n_no_line;

    logic [DW-1:0]         dx, dy, ax_full, ay_full;
    logic [COORD_BITS-1:0] ax, ay, len;
    logic                  dx_pos, dx_neg, dy_pos, dy_neg;
    logic [POS_W-1:0]      base_x, base_y;
    logic                  out_free;
    logic                  req_acc;
    logic                  div_start;
    logic [COORD_BITS-1:0] div_num;
    logic [COORD_BITS-1:0] div_den;
    dda_pkg::t_div_stat    div_stat;
    logic [QUO_W-1:0]      div_quo;
    logic [STEP_W-1:0]     quo_ext;

    // position to pixel, truncated toward zero
    function automatic logic [COORD_BITS-1:0] to_pixel(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] biased;
        biased = p + (p[POS_W-1] ? FRAC_MASK : '0);
        return biased[FRAC_BITS +: COORD_BITS];
    endfunction

    // shared divider
    dda_div #(
        .NUM_BITS (COORD_BITS),
        .QUO_BITS (QUO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // line geometry from the latched endpoints
    always_comb begin
        dx      = {r_x2[COORD_BITS-1], r_x2} - {r_x1[COORD_BITS-1], r_x1};
        dy      = {r_y2[COORD_BITS-1], r_y2} - {r_y1[COORD_BITS-1], r_y1};
        ax_full = dx[DW-1] ? (~dx + DW'(1)) : dx;
        ay_full = dy[DW-1] ? (~dy + DW'(1)) : dy;
        ax      = ax_full[COORD_BITS-1:0];
        ay      = ay_full[COORD_BITS-1:0];
        len     = (ax >= ay) ? ax : ay;
        dx_neg  = dx[DW-1];
        dy_neg  = dy[DW-1];
        dx_pos  = !dx[DW-1] && (dx != '0);
        dy_pos  = !dy[DW-1] && (dy != '0);
        base_x  = {r_x1[COORD_BITS-1], r_x1, {FRAC_BITS{1'b0}}};
        base_y  = {r_y1[COORD_BITS-1], r_y1, {FRAC_BITS{1'b0}}};
    end

    assign req_acc  = i_req.valid && (r_state == dda_pkg::S_IDLE);
    assign out_free = !r_out_valid || o_pix.ready;
    assign quo_ext  = {1'b0, div_quo};
    assign div_num  = (r_state == dda_pkg::S_SETUP) ? ax : r_ay;
    // the length is not yet registered when the x division starts
    assign div_den  = (r_state == dda_pkg::S_SETUP) ? len : r_len;

    // sequencer: next state and register updates
    always_comb begin
        n_state     = r_state;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_x2        = r_x2;
        n_y2        = r_y2;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_step_x    = r_step_x;
        n_step_y    = r_step_y;
        n_left      = r_left;
        n_active    = r_active;
        n_last      = r_last;
        n_noline    = r_noline;
        n_len       = r_len;
        n_ay        = r_ay;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_out_valid = r_out_valid && !o_pix.ready;
        n_pix_x     = r_pix_x;
        n_pix_y     = r_pix_y;
        n_is_last   = r_is_last;
        n_no_line   = r_no_line;
        div_start   = 1'b0;
        i_req.ready = 1'b0;

        case (r_state)
            dda_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (req_acc) begin
                    if (i_req.req_type == dda_pkg::REQ_START) begin
                        n_x1    = i_req.start_x;
                        n_y1    = i_req.start_y;
                        n_x2    = i_req.end_x;
                        n_y2    = i_req.end_y;
                        n_state = dda_pkg::S_SETUP;
                    end else if (!r_active || r_left == '0) begin
                        n_active = 1'b0;
                        n_noline = 1'b1;
                        n_last   = 1'b0;
                        n_state  = dda_pkg::S_OUT;
                    end else begin
                        n_pos_x  = r_pos_x + {{(POS_W-STEP_W){r_step_x[STEP_W-1]}}, r_step_x};
                        n_pos_y  = r_pos_y + {{(POS_W-STEP_W){r_step_y[STEP_W-1]}}, r_step_y};
                        n_left   = r_left - LEFT_W'(1);
                        n_active = (r_left != LEFT_W'(1));
                        n_last   = (r_left == LEFT_W'(1));
                        n_noline = 1'b0;
                        n_state  = dda_pkg::S_OUT;
                    end
                end
            end
            dda_pkg::S_SETUP: begin
                n_pos_x  = base_x + (dx_pos ? HALF : (dx_neg ? (~HALF + POS_W'(1)) : '0));
                n_pos_y  = base_y + (dy_pos ? HALF : (dy_neg ? (~HALF + POS_W'(1)) : '0));
                n_neg_x  = dx_neg;
                n_neg_y  = dy_neg;
                n_ay     = ay;
                n_len    = len;
                n_left   = {1'b0, len};
                n_active = (len != '0);
                n_last   = (len == '0);
                n_noline = 1'b0;
                if (len == '0) begin
                    n_step_x = '0;
                    n_step_y = '0;
                    n_state  = dda_pkg::S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = dda_pkg::S_DIV_X;
                end
            end
            dda_pkg::S_DIV_X: begin
                if (div_stat.done) begin
                    n_step_x  = r_neg_x ? (~quo_ext + STEP_W'(1)) : quo_ext;
                    div_start = 1'b1;
                    n_state   = dda_pkg::S_DIV_Y;
                end
            end
            dda_pkg::S_DIV_Y: begin
                if (div_stat.done) begin
                    n_step_y = r_neg_y ? (~quo_ext + STEP_W'(1)) : quo_ext;
                    n_state  = dda_pkg::S_OUT;
                end
            end
            dda_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_pix_x     = r_noline ? '0 : to_pixel(r_pos_x);
                    n_pix_y     = r_noline ? '0 : to_pixel(r_pos_y);
                    n_is_last   = r_last;
                    n_no_line   = r_noline;
                    n_state     = dda_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dda_pkg::S_IDLE;
            end
        endcase
    end

    // state register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dda_pkg::S_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_left      <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_step_x    <= n_step_x;
            r_step_y    <= n_step_y;
            r_left      <= n_left;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_x2      <= n_x2;
        r_y2      <= n_y2;
        r_last    <= n_last;
        r_noline  <= n_noline;
        r_len     <= n_len;
        r_ay      <= n_ay;
        r_neg_x   <= n_neg_x;
        r_neg_y   <= n_neg_y;
        r_pix_x   <= n_pix_x;
        r_pix_y   <= n_pix_y;
        r_is_last <= n_is_last;
        r_no_line <= n_no_line;
    end

    // output word
    assign o_pix.valid   = r_out_valid;
    assign o_pix.pixel_x = r_pix_x;
    assign o_pix.pixel_y = r_pix_y;
    assign o_pix.is_last = r_is_last;
    assign o_pix.no_line = r_no_line;

    // an active line always has points to give
    a_active_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_left != '0))
        else $error("active line with no points left");

    // the divider only runs while a start is being set up
    a_div_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.busy || div_stat.done) |->
            (r_state == dda_pkg::S_DIV_X || r_state == dda_pkg::S_DIV_Y))
        else $error("divider running outside the division states");

    // a step magnitude never exceeds one pixel
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (div_quo <= (QUO_W'(1) << FRAC_BITS)))
        else $error("step magnitude above one pixel");

    // a no-line word carries zero coordinates and no last flag
    a_no_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_no_line) |-> (r_pix_x == '0 && r_pix_y == '0 && !r_is_last))
        else $error("no-line word with non-zero payload");

    // a word is loaded only when leaving the output state
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == dda_pkg::S_OUT))
        else $error("output word loaded outside the output state");

endmodule

// ----- tb/sv/dda_line_rasterizer_test.sv -----
// self-checking testbench of the dda line rasterizer with its own fixed-point line stepper
module dda_line_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CB           = dda_pkg::COORD_BITS_DEF;
    localparam int     FB           = dda_pkg::FRAC_BITS_DEF;
    localparam int     ITEM_TARGET  = 1800;
    localparam int     DRAIN_CYCLES = 2 * FB + 16;
    localparam int     COORD_MIN    = -(2 ** (CB - 1));
    localparam int     COORD_MAX    = 2 ** (CB - 1) - 1;
    localparam longint HALF_PIXEL   = longint'(1) << (FB - 1);

    typedef struct {
        logic                 rtype;
        logic signed [CB-1:0] x0, y0, x1, y1;
    } t_line_req;

    typedef struct {
        logic signed [CB-1:0] px, py;
        logic                 last;
        logic                 no_line;
    } t_pixel_word;

    logic i_clk;
    logic i_rst_n;

    dda_req_if #(.COORD_BITS(CB)) req_ch ();
    dda_pix_if #(.COORD_BITS(CB)) pix_ch ();

    dda_line_rasterizer #(
        .COORD_BITS(CB),
        .FRAC_BITS (FB)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_pix  (pix_ch)
    );

    // pixel words still owed by the block, oldest first
    t_pixel_word pending_pixels[$];
    int          n_errors      = 0;
    int          n_sent        = 0;
    bit          tx_free       = 1'b0;
    bit          rx_free       = 1'b0;
    int          tx_burst_left = 0;
    int          rx_count      = 0;
    int          rx_off_len    = 0;

    // line state of the stepper, at the block's widths
    logic signed [CB+FB:0] line_pos_x  = '0;
    logic signed [CB+FB:0] line_pos_y  = '0;
    logic signed [FB+1:0]  line_step_x = '0;
    logic signed [FB+1:0]  line_step_y = '0;
    logic        [CB:0]    points_left = '0;
    bit                    line_active = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // position to pixel, truncated toward zero
    function automatic logic signed [CB-1:0] trunc_pixel(logic signed [CB+FB:0] p);
        longint v;
        v = p;
        if (v >= 0) v = v >>> FB;
        else        v = -((-v) >>> FB);
        return v[CB-1:0];
    endfunction

    // half a pixel in the direction of travel
    function automatic longint half_toward(longint d);
        if (d > 0) return HALF_PIXEL;
        if (d < 0) return -HALF_PIXEL;
        return 0;
    endfunction

    // one request through the line stepper, giving the pixel word it causes
    function automatic t_pixel_word rasterise_step(t_line_req w);
        t_pixel_word r;
        longint      dx, dy, ax, ay, len;
        r.px      = '0;
        r.py      = '0;
        r.last    = 1'b0;
        r.no_line = 1'b0;
        if (w.rtype == dda_pkg::REQ_START) begin
            dx  = longint'(w.x1) - longint'(w.x0);
            dy  = longint'(w.y1) - longint'(w.y0);
            ax  = (dx < 0) ? -dx : dx;
            ay  = (dy < 0) ? -dy : dy;
            len = (ax >= ay) ? ax : ay;
            if (len > 0) begin
                line_step_x = (FB + 2)'((dx <<< FB) / len);
                line_step_y = (FB + 2)'((dy <<< FB) / len);
            end else begin
                line_step_x = '0;
                line_step_y = '0;
            end
            line_pos_x  = (CB + FB + 1)'((longint'(w.x0) <<< FB) + half_toward(dx));
            line_pos_y  = (CB + FB + 1)'((longint'(w.y0) <<< FB) + half_toward(dy));
            points_left = len[CB:0];
            line_active = (len > 0);
            r.px        = trunc_pixel(line_pos_x);
            r.py        = trunc_pixel(line_pos_y);
            r.last      = (len == 0);
        end else if (!line_active || points_left == 0) begin
            line_active = 1'b0;
            r.no_line   = 1'b1;
        end else begin
            line_pos_x  = line_pos_x + line_step_x;
            line_pos_y  = line_pos_y + line_step_y;
            points_left = points_left - 1'b1;
            line_active = (points_left != 0);
            r.px        = trunc_pixel(line_pos_x);
            r.py        = trunc_pixel(line_pos_y);
            r.last      = (points_left == 0);
        end
        return r;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        return r[CB-1:0];
    endfunction

    // a coordinate within span of c, kept inside the field's range
    function automatic logic signed [CB-1:0] near_coord(logic signed [CB-1:0] c, int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < COORD_MIN) v = COORD_MIN;
        if (v > COORD_MAX) v = COORD_MAX;
        return v[CB-1:0];
    endfunction

    // send one request word, then maybe a gap at the end of a burst
    task automatic send_word(input logic rtype,
                             input logic signed [CB-1:0] x0, y0, x1, y1);
        t_line_req w;
        int        gap;
        w.rtype = rtype;
        w.x0    = x0;
        w.y0    = y0;
        w.x1    = x1;
        w.y1    = y1;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.start_x  <= x0;
        req_ch.start_y  <= y0;
        req_ch.end_x    <= x1;
        req_ch.end_y    <= y1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_pixels.push_back(rasterise_step(w));
        n_sent++;
        if (!tx_free) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 20);
                gap           = $urandom_range(1, 8);
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                tx_burst_left--;
            end
        end
    endtask

    task automatic start_line(input logic signed [CB-1:0] x0, y0, x1, y1);
        send_word(dda_pkg::REQ_START, x0, y0, x1, y1);
    endtask

    // advance words carry random endpoints, which the block must ignore
    task automatic advance(input int n);
        repeat (n) send_word(dda_pkg::REQ_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord());
    endtask

    // hold the sender until every owed word has come out
    task automatic drain_pixels();
        req_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // extremes, zero-length lines, dropped lines and advances past the end
    task automatic test_directed_lines();
        advance(1);
        start_line(0, 0, 0, 0);
        advance(1);
        start_line(-2048, 2047, 2047, -2048);
        advance(2);
        start_line(2047, -2048, 2047, -2048);
        advance(1);
        start_line(-2048, -2048, -2045, -2047);
        advance(4);
        start_line(5, 5, 1, 8);
        advance(4);
        start_line(3, -3, 3, 0);
        advance(3);
        start_line(-1, -1, -3, -1);
        advance(2);
    endtask

    // a long line walked to its end and past it, with no idling on either side
    task automatic test_long_line();
        tx_free = 1'b1;
        rx_free = 1'b1;
        start_line(-2048, 2047, -1348, 1500);
        advance(701);
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    // one line of random shape, walked fully, past its end or dropped early
    task automatic random_line();
        logic signed [CB-1:0] x0, y0, x1, y1;
        int                   kind, pick, dx, dy, len, n_adv;
        x0   = rand_coord();
        y0   = rand_coord();
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            x1 = x0;
            y1 = y0;
        end else if (kind < 15) begin
            x1 = rand_coord();
            y1 = rand_coord();
        end else if (kind < 25) begin
            x1 = x0;
            y1 = y0;
            if ($urandom_range(0, 1) == 0) x1 = near_coord(x0, 20);
            else                           y1 = near_coord(y0, 20);
        end else begin
            x1 = near_coord(x0, (kind < 45) ? 60 : 12);
            y1 = near_coord(y0, (kind < 45) ? 60 : 12);
        end
        dx  = int'(x1) - int'(x0);
        dy  = int'(y1) - int'(y0);
        dx  = (dx < 0) ? -dx : dx;
        dy  = (dy < 0) ? -dy : dy;
        len = (dx >= dy) ? dx : dy;
        start_line(x0, y0, x1, y1);
        if (kind >= 5 && kind < 15) begin
            n_adv = $urandom_range(0, 24);
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 15)      n_adv = len;
            else if (pick < 17) n_adv = len + $urandom_range(1, 2);
            else                n_adv = $urandom_range(0, len);
        end
        advance(n_adv);
    endtask

    // random lines in phases of differing idling, with a full drain now and then
    task automatic test_random_lines();
        int n_lines;
        n_lines = 0;
        while (n_sent < ITEM_TARGET) begin
            if (n_lines % 40 == 0) begin
                tx_free = ($urandom_range(0, 3) == 0);
                rx_free = ($urandom_range(0, 3) == 0);
            end
            if (n_lines % 25 == 24) drain_pixels();
            if ($urandom_range(0, 19) == 0) advance(1);
            random_line();
            n_lines++;
        end
    endtask

    // receiver ready: runs of ready broken by stalls
    always @(posedge i_clk) begin
        if (rx_count == 0) begin
            rx_off_len = rx_free ? 0 : $urandom_range(1, 6);
            rx_count   = $urandom_range(1, 12) + rx_off_len;
        end
        pix_ch.ready <= rx_free || (rx_count > rx_off_len);
        rx_count = rx_count - 1;
    end

    // compare each accepted pixel word with the oldest one owed
    always @(posedge i_clk) begin
        t_pixel_word want;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel word with none owed: x %0d y %0d", pix_ch.pixel_x, pix_ch.pixel_y);
                n_errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (pix_ch.pixel_x !== want.px) begin
                    $error("pixel_x: expected %0d, got %0d", want.px, pix_ch.pixel_x);
                    n_errors++;
                end
                if (pix_ch.pixel_y !== want.py) begin
                    $error("pixel_y: expected %0d, got %0d", want.py, pix_ch.pixel_y);
                    n_errors++;
                end
                if (pix_ch.is_last !== want.last) begin
                    $error("is_last: expected %0b, got %0b", want.last, pix_ch.is_last);
                    n_errors++;
                end
                if (pix_ch.no_line !== want.no_line) begin
                    $error("no_line: expected %0b, got %0b", want.no_line, pix_ch.no_line);
                    n_errors++;
                end
            end
        end
    end

    // test sequence
    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= dda_pkg::REQ_ADVANCE;
        req_ch.start_x  <= '0;
        req_ch.start_y  <= '0;
        req_ch.end_x    <= '0;
        req_ch.end_y    <= '0;
        i_rst_n         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_lines();
        test_long_line();
        test_random_lines();
        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("dda_line_rasterizer_test OK");
        end else begin
            $display("dda_line_rasterizer_test NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("dda_line_rasterizer_test NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
sv/dda_pkg.sv
sv/dda_if.sv
sv/dda_div.sv
sv/dda_line_rasterizer.sv
tb/sv/dda_line_rasterizer_test.sv
